[sv/cursor_linked_list_engine_core_defines.svh]
// Assertion macros for the list engine checker.
`ifndef CURSOR_LINKED_LIST_ENGINE_CORE_DEFINES_SVH
`define CURSOR_LINKED_LIST_ENGINE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLL_ASSERT_SAME(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CLL_ASSERT_NEXT(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/cll_pkg.sv]
// Types and constants for the cursor linked list engine.
`timescale 1ns / 1ps
`default_nettype none

package cll_pkg;

	localparam int WORD_W   = 32;
	localparam int CMD_W    = 4;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	localparam logic [CMD_W-1:0] CMD_FIRST      = 4'd0;
	localparam logic [CMD_W-1:0] CMD_NEXT       = 4'd1;
	localparam logic [CMD_W-1:0] CMD_LAST       = 4'd2;
	localparam logic [CMD_W-1:0] CMD_PREV       = 4'd3;
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd4;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd5;
	localparam logic [CMD_W-1:0] CMD_INSERT     = 4'd6;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd7;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd8;
	localparam logic [CMD_W-1:0] CMD_POP_CURSOR = 4'd9;
	localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd10;

	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY       = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_NEIGHBOR = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL        = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_STEP,
		S_MOVE_DONE,
		S_TAKE,
		S_PLACE,
		S_AFTER,
		S_FRONT2,
		S_UNLINK,
		S_FREE,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [WORD_W-1:0] payload_in;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0]   payload_out;
		logic                has_payload;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  entry_count;
	} out_item_t;

endpackage

`default_nettype wire

[sv/cursor_linked_list_engine_core.sv]
// Top level of the cursor linked list engine: sequencer, link memories and result register.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a doubly linked list of words in a pool of POOL_NODES nodes with head, tail and a
// cursor, and answers every command with one result item. Commands run one at a time under
// a small sequencer around three node memories (word, forward link, backward link), each
// with one write port and one registered read port.
// Clear, unknown codes and commands refused at once (empty list, no cursor, full pool) go
// straight from dispatch to the result; first and last add a word read, next and prev a
// link read and, on a neighbor, a word read; pops read, unlink and free the node; pushes
// place and link the node, reading the free chain first when they reuse a freed node.
// A finished result waits in the output register while the next item is accepted. No
// clearing pass: link memories hold junk until written, and only written entries are
// ever followed.
module cursor_linked_list_engine_core #(
	parameter int POOL_NODES = 64,
	parameter int WORD_BITS  = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire cll_pkg::in_item_t in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output cll_pkg::out_item_t     out_data
);
	import cll_pkg::*;

	localparam int IDX_W  = $clog2(POOL_NODES);
	localparam int NODE_W = $clog2(POOL_NODES + 1);
	localparam logic [NODE_W-1:0] NIL = NODE_W'(POOL_NODES);

	function automatic logic is_node(input logic [NODE_W-1:0] x);
		return x < NIL;
	endfunction

	state_t state_q, state_d;

	logic [CMD_W-1:0]     cmd_q, cmd_d;
	logic [WORD_BITS-1:0] word_q, word_d;
	logic [NODE_W-1:0]    n_q, n_d;
	logic [NODE_W-1:0]    first_q, first_d;
	logic [NODE_W-1:0]    final_q, final_d;
	logic [NODE_W-1:0]    cursor_q, cursor_d;
	logic [NODE_W-1:0]    free_q, free_d;
	logic [NODE_W-1:0]    mark_q, mark_d;
	logic [NODE_W-1:0]    count_q, count_d;
	logic [WORD_BITS-1:0] res_pay_q, res_pay_d;
	logic                 res_has_q, res_has_d;
	logic [STATUS_W-1:0]  res_status_q, res_status_d;
	logic                 out_valid_q, out_valid_d;
	logic                 out_load;
	out_item_t            out_q;

	// node memories
	logic [WORD_BITS-1:0] pay_mem [POOL_NODES];
	logic [NODE_W-1:0]    fwd_mem [POOL_NODES];
	logic [NODE_W-1:0]    bwd_mem [POOL_NODES];
	logic [WORD_BITS-1:0] pay_rd_q;
	logic [NODE_W-1:0]    fwd_rd_q, bwd_rd_q;
	logic [NODE_W-1:0]    rd_addr;
	logic                 pay_we, fwd_we, bwd_we;
	logic [NODE_W-1:0]    pay_wa, fwd_wa, bwd_wa;
	logic [WORD_BITS-1:0] pay_wd;
	logic [NODE_W-1:0]    fwd_wd, bwd_wd;

	logic                      empty;
	logic                      pool_full;
	logic [NODE_W-1:0]         move_tgt;
	logic [NODE_W-1:0]         step_n;
	logic [NODE_W-1:0]         pop_c;
	logic                      after_mode;
	logic [WORD_BITS+WORD_W-1:0] word_ext;
	logic [WORD_W+WORD_BITS-1:0] pay_ext;
	logic [COUNT_W+NODE_W-1:0]   count_ext;

	assign empty      = !is_node(first_q);
	assign pool_full  = !is_node(free_q) && !(mark_q < NIL);
	assign move_tgt   = (cmd_q == CMD_FIRST) ? first_q : final_q;
	assign step_n     = (cmd_q == CMD_NEXT) ? fwd_rd_q : bwd_rd_q;
	assign pop_c      = (cmd_q == CMD_POP_FRONT) ? first_q :
	                    (cmd_q == CMD_POP_BACK)  ? final_q : cursor_q;
	assign after_mode = (cmd_q != CMD_PUSH_FRONT) && is_node(cursor_q);
	assign word_ext   = {{WORD_BITS{1'b0}}, in_data.payload_in};
	assign pay_ext    = {{WORD_W{1'b0}}, res_pay_q};
	assign count_ext  = {{COUNT_W{1'b0}}, count_q};

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_load  = (state_q == S_RESP) && (!out_valid_q || !out_stall);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				unique case (cmd_q) inside
					CMD_FIRST, CMD_LAST: begin
						state_d = empty ? S_RESP : S_MOVE_DONE;
					end
					CMD_NEXT, CMD_PREV: begin
						state_d = (empty || !is_node(cursor_q)) ? S_RESP : S_STEP;
					end
					CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
						if (is_node(free_q))    state_d = S_TAKE;
						else if (mark_q < NIL)  state_d = S_PLACE;
						else                    state_d = S_RESP;
					end
					CMD_POP_FRONT, CMD_POP_BACK, CMD_POP_CURSOR: begin
						state_d = (empty || !is_node(pop_c)) ? S_RESP : S_UNLINK;
					end
					default: state_d = S_RESP;
				endcase
			end
			S_STEP:      state_d = is_node(step_n) ? S_MOVE_DONE : S_RESP;
			S_MOVE_DONE: state_d = S_RESP;
			S_TAKE:      state_d = S_PLACE;
			S_PLACE:     state_d = after_mode ? S_AFTER : S_FRONT2;
			S_AFTER:     state_d = S_RESP;
			S_FRONT2:    state_d = S_RESP;
			S_UNLINK:    state_d = S_FREE;
			S_FREE:      state_d = S_RESP;
			S_RESP: begin
				if (!out_valid_q || !out_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath control and register updates
	always_comb begin
		cmd_d        = cmd_q;
		word_d       = word_q;
		n_d          = n_q;
		first_d      = first_q;
		final_d      = final_q;
		cursor_d     = cursor_q;
		free_d       = free_q;
		mark_d       = mark_q;
		count_d      = count_q;
		res_pay_d    = res_pay_q;
		res_has_d    = res_has_q;
		res_status_d = res_status_q;
		rd_addr      = '0;
		pay_we       = 1'b0;
		pay_wa       = '0;
		pay_wd       = word_q;
		fwd_we       = 1'b0;
		fwd_wa       = '0;
		fwd_wd       = '0;
		bwd_we       = 1'b0;
		bwd_wa       = '0;
		bwd_wd       = '0;
		out_valid_d  = out_valid_q && out_stall;
		unique case (state_q)
			S_IDLE: begin
				cmd_d  = in_data.command;
				word_d = word_ext[WORD_BITS-1:0];
			end
			S_DISPATCH: begin
				res_pay_d    = '0;
				res_has_d    = 1'b0;
				res_status_d = ST_OK;
				unique case (cmd_q) inside
					CMD_FIRST, CMD_LAST: begin
						if (empty) begin
							res_status_d = ST_EMPTY;
						end else begin
							cursor_d = move_tgt;
							rd_addr  = move_tgt;
						end
					end
					CMD_NEXT, CMD_PREV: begin
						if (empty)                  res_status_d = ST_EMPTY;
						else if (!is_node(cursor_q)) res_status_d = ST_NO_NEIGHBOR;
						else                        rd_addr = cursor_q;
					end
					CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
						if (is_node(free_q)) begin
							rd_addr = free_q;
						end else if (mark_q < NIL) begin
							n_d    = mark_q;
							mark_d = mark_q + NODE_W'(1);
						end else begin
							res_status_d = ST_FULL;
						end
						// a back push links after the old tail
						if (!pool_full && cmd_q == CMD_PUSH_BACK) cursor_d = final_q;
					end
					CMD_POP_FRONT, CMD_POP_BACK, CMD_POP_CURSOR: begin
						cursor_d = pop_c;
						n_d      = pop_c;
						if (empty)                res_status_d = ST_EMPTY;
						else if (!is_node(pop_c)) res_status_d = ST_NO_NEIGHBOR;
						else                      rd_addr = pop_c;
					end
					CMD_CLEAR: begin
						// splice the whole list onto the free chain
						if (is_node(first_q) && is_node(final_q)) begin
							fwd_we = 1'b1;
							fwd_wa = final_q;
							fwd_wd = free_q;
							free_d = first_q;
						end
						first_d  = NIL;
						final_d  = NIL;
						cursor_d = NIL;
						count_d  = '0;
					end
					default: ;
				endcase
			end
			S_STEP: begin
				if (is_node(step_n)) begin
					cursor_d = step_n;
					rd_addr  = step_n;
				end else begin
					res_status_d = ST_NO_NEIGHBOR;
				end
			end
			S_MOVE_DONE: begin
				res_pay_d = pay_rd_q;
				res_has_d = 1'b1;
			end
			S_TAKE: begin
				n_d    = free_q;
				free_d = fwd_rd_q;
			end
			S_PLACE: begin
				pay_we  = 1'b1;
				pay_wa  = n_q;
				pay_wd  = word_q;
				count_d = count_q + NODE_W'(1);
				if (after_mode) begin
					// read the old successor while the cursor link is overwritten
					rd_addr = cursor_q;
					bwd_we  = 1'b1;
					bwd_wa  = n_q;
					bwd_wd  = cursor_q;
					fwd_we  = 1'b1;
					fwd_wa  = cursor_q;
					fwd_wd  = n_q;
				end else begin
					fwd_we = 1'b1;
					fwd_wa = n_q;
					fwd_wd = first_q;
					if (is_node(first_q)) begin
						bwd_we = 1'b1;
						bwd_wa = first_q;
						bwd_wd = n_q;
					end else begin
						final_d = n_q;
					end
					first_d = n_q;
				end
			end
			S_AFTER: begin
				fwd_we = 1'b1;
				fwd_wa = n_q;
				fwd_wd = fwd_rd_q;
				if (is_node(fwd_rd_q)) begin
					bwd_we = 1'b1;
					bwd_wa = fwd_rd_q;
					bwd_wd = n_q;
				end else begin
					final_d = n_q;
				end
			end
			S_FRONT2: begin
				bwd_we = 1'b1;
				bwd_wa = n_q;
				bwd_wd = NIL;
			end
			S_UNLINK: begin
				res_pay_d = pay_rd_q;
				res_has_d = 1'b1;
				if (is_node(bwd_rd_q)) begin
					fwd_we = 1'b1;
					fwd_wa = bwd_rd_q;
					fwd_wd = fwd_rd_q;
				end else begin
					first_d = fwd_rd_q;
				end
				if (is_node(fwd_rd_q)) begin
					bwd_we = 1'b1;
					bwd_wa = fwd_rd_q;
					bwd_wd = bwd_rd_q;
				end else begin
					final_d = bwd_rd_q;
				end
				cursor_d = is_node(fwd_rd_q) ? fwd_rd_q : bwd_rd_q;
				if (count_q != '0) count_d = count_q - NODE_W'(1);
			end
			S_FREE: begin
				fwd_we = 1'b1;
				fwd_wa = n_q;
				fwd_wd = free_q;
				free_d = n_q;
			end
			S_RESP: begin
				if (out_load) out_valid_d = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			first_q     <= NIL;
			final_q     <= NIL;
			cursor_q    <= NIL;
			free_q      <= NIL;
			mark_q      <= '0;
			count_q     <= '0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
			first_q     <= first_d;
			final_q     <= final_d;
			cursor_q    <= cursor_d;
			free_q      <= free_d;
			mark_q      <= mark_d;
			count_q     <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q        <= cmd_d;
		word_q       <= word_d;
		n_q          <= n_d;
		res_pay_q    <= res_pay_d;
		res_has_q    <= res_has_d;
		res_status_q <= res_status_d;
		if (out_load) begin
			out_q.payload_out <= pay_ext[WORD_W-1:0];
			out_q.has_payload <= res_has_q;
			out_q.status      <= res_status_q;
			out_q.entry_count <= count_ext[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (pay_we) pay_mem[pay_wa[IDX_W-1:0]] <= pay_wd;
		pay_rd_q <= pay_mem[rd_addr[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (fwd_we) fwd_mem[fwd_wa[IDX_W-1:0]] <= fwd_wd;
		fwd_rd_q <= fwd_mem[rd_addr[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (bwd_we) bwd_mem[bwd_wa[IDX_W-1:0]] <= bwd_wd;
		bwd_rd_q <= bwd_mem[rd_addr[IDX_W-1:0]];
	end

endmodule

`default_nettype wire

[sv/cll_checker.sv]
// Port checker for the cursor linked list engine and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "cursor_linked_list_engine_core_defines.svh"

module cll_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire cll_pkg::out_item_t out_data
);
	import cll_pkg::*;

	`CLL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")
	`CLL_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "item accepted while previous one still in work")
	`CLL_ASSERT_SAME(a_null_word, clk, arst_n, out_valid && !out_data.has_payload, out_data.payload_out == '0, "null result carries a word")
	`CLL_ASSERT_SAME(a_error_no_word, clk, arst_n, out_valid && out_data.status != ST_OK, !out_data.has_payload, "failed command returned a word")

endmodule

bind cursor_linked_list_engine_core cll_checker u_cll_checker (.*);

`default_nettype wire
